@@ rtl/log_line_control_char_escaper_core_defines.svh @@
// Assertion macros shared by the escaper checker.
`ifndef LOG_LINE_CONTROL_CHAR_ESCAPER_CORE_DEFINES_SVH
`define LOG_LINE_CONTROL_CHAR_ESCAPER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LCCE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("escaper check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LCCE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("escaper check failed");

`endif

@@ rtl/lcce_pkg.sv @@
// Types, constants and register codes of the control character escaper.
package lcce_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int MAX_LINE_BITS      = 16;
   localparam int CSR_INDEX_BITS     = 4;
   localparam int CSR_DATA_BITS      = 16;
   localparam int JOB_QUEUE_DEPTH    = 2;
   localparam int RSP_QUEUE_DEPTH    = 2;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_LINE        = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ESCAPE_CHAR     = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ESCAPE_CONTROL  = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DROP_TRAILING_LF = 4'd3;

   localparam logic [MAX_LINE_BITS-1:0] MAX_LINE_RESET    = 16'd2048;
   localparam logic [7:0]               ESCAPE_CHAR_RESET = 8'd35;

   localparam logic [7:0] CHAR_Z    = 8'h7A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_DEL  = 8'h7F;
   localparam logic [7:0] CTRL_TOP  = 8'h20;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       line_done;
      logic       message_dropped;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [MAX_LINE_BITS-1:0] max_line;
      logic [7:0]               escape_char;
      logic                     escape_control;
      logic                     drop_trailing_lf;
   } cfg_type;

   // work handed from front to back for one accepted beat
   typedef struct packed {
      logic            drop;        // reject result first
      logic [1:0]      nbytes;      // bytes to emit, 0..3
      logic [2:0][7:0] bytes;       // bytes[0] goes out first
      logic            close_line;  // line end closes the message
   } job_type;

endpackage

@@ rtl/lcce_queue.sv @@
// Small first-in first-out queue used between the escaper stages.
module lcce_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntBits = $clog2(DEPTH + 1);
   localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);

   item_type             mem_ff [DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CntBits'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/lcce_front.sv @@
// Front stage: holds back the two newest bytes, trims the tail, rejects messages.
module lcce_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  lcce_pkg::req_type req_data,
   input  lcce_pkg::cfg_type cfg,
   output logic             job_push,
   output lcce_pkg::job_type job
);

   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic [1:0] held_count_ff, held_count_in;
   logic       at_first_ff, at_first_in;
   logic       rejected_ff, rejected_in;

   logic       reject_now;
   logic       rejecting;
   logic [7:0] b;
   logic [7:0] t0, t1, t2, tail_last;
   logic [1:0] cnt;

   always_comb begin
      b          = req_data.in_byte;
      reject_now = at_first_ff && (b == lcce_pkg::CHAR_Z);
      rejecting  = rejected_ff || reject_now;

      t0 = b;
      t1 = b;
      t2 = b;
      cnt = 2'd1;
      case (held_count_ff)
         2'd0: begin
            t0 = b;
            cnt = 2'd1;
         end
         2'd1: begin
            t0 = held0_ff;
            t1 = b;
            cnt = 2'd2;
         end
         default: begin
            t0 = held0_ff;
            t1 = held1_ff;
            t2 = b;
            cnt = 2'd3;
         end
      endcase
      // trailing NUL goes first, then a trailing LF if enabled
      if (b == lcce_pkg::CHAR_NUL) begin
         cnt = cnt - 2'd1;
      end
      tail_last = (cnt == 2'd1) ? t0 : ((cnt == 2'd2) ? t1 : t2);
      if (cfg.drop_trailing_lf && (cnt != 2'd0) && (tail_last == lcce_pkg::CHAR_LF)) begin
         cnt = cnt - 2'd1;
      end

      job      = '0;
      job.drop = reject_now;
      if (!req_data.last_byte) begin
         if (!rejecting && (held_count_ff == 2'd2)) begin
            job.nbytes   = 2'd1;
            job.bytes[0] = held0_ff;
         end
      end else if (!rejecting) begin
         job.nbytes     = cnt;
         job.bytes[0]   = t0;
         job.bytes[1]   = t1;
         job.bytes[2]   = t2;
         job.close_line = 1'b1;
      end
      job_push = accept && (job.drop || (job.nbytes != 2'd0) || job.close_line);

      held0_in      = held0_ff;
      held1_in      = held1_ff;
      held_count_in = held_count_ff;
      at_first_in   = at_first_ff;
      rejected_in   = rejected_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            held_count_in = 2'd0;
            at_first_in   = 1'b1;
            rejected_in   = 1'b0;
         end else begin
            at_first_in = 1'b0;
            rejected_in = rejecting;
            if (!rejecting) begin
               case (held_count_ff)
                  2'd0: begin
                     held0_in      = b;
                     held_count_in = 2'd1;
                  end
                  2'd1: begin
                     held1_in      = b;
                     held_count_in = 2'd2;
                  end
                  default: begin
                     held0_in = held1_ff;
                     held1_in = b;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         at_first_ff   <= 1'b1;
         rejected_ff   <= 1'b0;
      end else begin
         held_count_ff <= held_count_in;
         at_first_ff   <= at_first_in;
         rejected_ff   <= rejected_in;
      end
   end

   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

endmodule

@@ rtl/lcce_back.sv @@
// Back stage: walks one job per pass, expands escapes, applies the line limit.
module lcce_back #(
   parameter int COUNT_BITS = lcce_pkg::COUNT_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  lcce_pkg::cfg_type  cfg,
   input  logic              job_valid,
   input  lcce_pkg::job_type  job,
   output logic              job_pop,
   input  logic              res_full,
   output logic              res_push,
   output lcce_pkg::rsp_type  res_data
);

   localparam int LimW = (COUNT_BITS > lcce_pkg::MAX_LINE_BITS) ?
                         COUNT_BITS : lcce_pkg::MAX_LINE_BITS;
   localparam logic [LimW-1:0] CountMax = LimW'((64'd1 << COUNT_BITS) - 64'd1);

   logic                  drop_done_ff, drop_done_in;
   logic [1:0]            byte_idx_ff, byte_idx_in;
   logic [1:0]            digit_ff, digit_in;
   logic [COUNT_BITS-1:0] line_count_ff, line_count_in;
   logic                  truncated_ff, truncated_in;
   lcce_pkg::rsp_type     pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_closed_ff, pend_closed_in;

   logic              step_ok;
   logic              gen;
   lcce_pkg::rsp_type gen_res;
   logic              job_last;
   logic              item_done;
   logic [7:0]        cur;
   logic              needs_escape;
   logic [LimW-1:0]   lim, max_ext, lc_w;
   logic              at_limit, has_room;

   assign max_ext  = LimW'(cfg.max_line);
   assign lim      = (max_ext < CountMax) ? max_ext : CountMax;
   assign lc_w     = LimW'(line_count_ff);
   assign at_limit = (lc_w >= lim);
   assign has_room = (({1'b0, lc_w} + (LimW + 1)'(3)) < {1'b0, lim});
   assign cur      = job.bytes[byte_idx_ff];
   assign needs_escape = (cur == lcce_pkg::CHAR_NUL) ||
                         (cfg.escape_control &&
                          ((cur < lcce_pkg::CTRL_TOP) || (cur == lcce_pkg::CHAR_DEL)));

   // a step may produce one result; it needs room only if the pending one must move
   assign step_ok  = job_valid && (!pend_valid_ff || !res_full);
   assign job_pop  = step_ok && job_last;
   assign res_push = pend_valid_ff && !res_full && (pend_closed_ff || (step_ok && gen));

   always_comb begin
      res_data             = pend_ff;
      res_data.last_of_run = pend_closed_ff;
   end

   always_comb begin
      gen           = 1'b0;
      gen_res       = '0;
      job_last      = 1'b0;
      item_done     = 1'b1;
      drop_done_in  = drop_done_ff;
      byte_idx_in   = byte_idx_ff;
      digit_in      = digit_ff;
      line_count_in = line_count_ff;
      truncated_in  = truncated_ff;

      if (job.drop && !drop_done_ff) begin
         gen                     = 1'b1;
         gen_res.message_dropped = 1'b1;
         drop_done_in            = 1'b1;
         job_last                = (job.nbytes == 2'd0) && !job.close_line;
      end else if (byte_idx_ff < job.nbytes) begin
         if (truncated_ff) begin
            gen = 1'b0;
         end else if (at_limit) begin
            gen               = 1'b1;
            gen_res.line_done = 1'b1;
            truncated_in      = 1'b1;
         end else if (needs_escape) begin
            if (has_room) begin
               gen              = 1'b1;
               gen_res.has_byte = 1'b1;
               case (digit_ff)
                  2'd0:    gen_res.out_byte = cfg.escape_char;
                  2'd1:    gen_res.out_byte = lcce_pkg::CHAR_ZERO + {6'd0, cur[7:6]};
                  2'd2:    gen_res.out_byte = lcce_pkg::CHAR_ZERO + {5'd0, cur[5:3]};
                  default: gen_res.out_byte = lcce_pkg::CHAR_ZERO + {5'd0, cur[2:0]};
               endcase
               item_done = (digit_ff == 2'd3);
               digit_in  = digit_ff + 2'd1;
               if (item_done) begin
                  line_count_in = line_count_ff + COUNT_BITS'(4);
               end
            end
         end else begin
            gen              = 1'b1;
            gen_res.has_byte = 1'b1;
            gen_res.out_byte = cur;
            line_count_in    = line_count_ff + COUNT_BITS'(1);
         end
         if (item_done) begin
            byte_idx_in = byte_idx_ff + 2'd1;
            digit_in    = 2'd0;
            job_last    = ((byte_idx_ff + 2'd1) == job.nbytes) && !job.close_line;
         end
      end else begin
         // line end: report unless already cut, then reset line state
         gen               = !truncated_ff;
         gen_res.line_done = !truncated_ff;
         line_count_in     = '0;
         truncated_in      = 1'b0;
         job_last          = 1'b1;
      end

      if (job_last) begin
         drop_done_in = 1'b0;
         byte_idx_in  = 2'd0;
         digit_in     = 2'd0;
      end

      pend_in        = pend_ff;
      pend_valid_in  = pend_valid_ff;
      pend_closed_in = pend_closed_ff;
      if (step_ok && gen) begin
         pend_in        = gen_res;
         pend_valid_in  = 1'b1;
         pend_closed_in = job_last;
      end else begin
         if (res_push) begin
            pend_valid_in  = 1'b0;
            pend_closed_in = 1'b0;
         end else if (step_ok && job_last && pend_valid_ff) begin
            pend_closed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_done_ff   <= 1'b0;
         byte_idx_ff    <= 2'd0;
         digit_ff       <= 2'd0;
         line_count_ff  <= '0;
         truncated_ff   <= 1'b0;
         pend_valid_ff  <= 1'b0;
         pend_closed_ff <= 1'b0;
      end else begin
         if (step_ok) begin
            drop_done_ff  <= drop_done_in;
            byte_idx_ff   <= byte_idx_in;
            digit_ff      <= digit_in;
            line_count_ff <= line_count_in;
            truncated_ff  <= truncated_in;
         end
         pend_valid_ff  <= pend_valid_in;
         pend_closed_ff <= pend_closed_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

@@ rtl/log_line_control_char_escaper_core.sv @@
// Top level of the log line control character escaper.
//
//   channel   ports                          beat
//   req       req_push / req_full            one message byte, last byte marked
//   rsp       rsp_empty / rsp_pop            one result of the cleaned line
//   csr       csr_valid / csr_ready          one register write
//
// One req beat of plain bytes is taken every cycle while req_full is low;
// results pass the job queue, the back pending register and the rsp queue.
// An escaped byte gives four rsp beats, one per back-stage cycle unless stalled;
// the last byte of a message gives up to three bytes plus the line end.
// req_full rises while the job queue between front and back is full.
// Reset is synchronous and clears control state; payload storage is not cleared.
// Configuration must be written only while idle (unchecked); csr_ready stays 1.
module log_line_control_char_escaper_core #(
   parameter int COUNT_BITS = lcce_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  lcce_pkg::req_type                     req_data,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output lcce_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lcce_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lcce_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   lcce_pkg::cfg_type cfg_ff, cfg_in;

   logic              req_accept;
   logic              job_push, job_full, job_empty, job_pop;
   lcce_pkg::job_type job_wr, job_rd;
   logic              res_push, res_full;
   lcce_pkg::rsp_type res_wr;

   assign csr_ready  = 1'b1;
   assign req_full   = job_full;
   assign req_accept = req_push && !job_full;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lcce_pkg::REG_MAX_LINE:
               cfg_in.max_line = csr_wdata[lcce_pkg::MAX_LINE_BITS-1:0];
            lcce_pkg::REG_ESCAPE_CHAR:       cfg_in.escape_char      = csr_wdata[7:0];
            lcce_pkg::REG_ESCAPE_CONTROL:    cfg_in.escape_control   = csr_wdata[0];
            lcce_pkg::REG_DROP_TRAILING_LF:  cfg_in.drop_trailing_lf = csr_wdata[0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_line         <= lcce_pkg::MAX_LINE_RESET;
         cfg_ff.escape_char      <= lcce_pkg::ESCAPE_CHAR_RESET;
         cfg_ff.escape_control   <= 1'b1;
         cfg_ff.drop_trailing_lf <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: tail holding, trimming and rejection
   lcce_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .job_push (job_push),
      .job      (job_wr)
   );

   // decouples front from back so each stalls on its own
   lcce_queue #(
      .item_type (lcce_pkg::job_type),
      .DEPTH     (lcce_pkg::JOB_QUEUE_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wr),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_rd),
      .empty     (job_empty)
   );

   // back: escaping, line limit, line end, last-of-run marking
   lcce_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (!job_empty),
      .job       (job_rd),
      .job_pop   (job_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_wr)
   );

   // result side looks like a queue to the consumer
   lcce_queue #(
      .item_type (lcce_pkg::rsp_type),
      .DEPTH     (lcce_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_wr),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

@@ rtl/lcce_checker.sv @@
// Port-level checks of the escaper, bound to the top level.
`include "log_line_control_char_escaper_core_defines.svh"

module lcce_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input lcce_pkg::rsp_type rsp_data
);

   // a reject result is alone for its beat, so it always closes the run
   `LCCE_ASSERT_SAME(a_drop_closes_run, !rsp_empty && rsp_data.message_dropped, rsp_data.last_of_run)

   // every result carries a byte, a line end or a reject
   `LCCE_ASSERT_SAME(a_result_kind, !rsp_empty, rsp_data.has_byte || rsp_data.line_done || rsp_data.message_dropped)

   // non-byte results carry a zero byte
   `LCCE_ASSERT_SAME(a_byte_zero, !rsp_empty && !rsp_data.has_byte, rsp_data.out_byte == 8'd0)

   // a result that is not taken stays put
   `LCCE_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

endmodule

bind log_line_control_char_escaper_core lcce_checker u_lcce_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

@@ tb/sv/tb.sv @@
// Testbench for the log line control character escaper: scoreboard with line predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcce_pkg::*;

   // Effective line limit can never exceed what the line counter holds.
   localparam int LINE_COUNT_MAX = (1 << COUNT_BITS_DEFAULT) - 1;
   // Worst case is far below this: ~350 bytes, random pop stalls.
   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT = 38;

   // Where the current message stands in the predictor.
   typedef enum logic [1:0] {LINE_OPEN, LINE_CUT, LINE_REJECTED} line_mode_e;

   // DUT ports; every input is known from time zero.
   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_push  = 1'b0;
   logic                      req_full;
   req_type                   req_data  = '0;
   logic                      rsp_empty;
   logic                      rsp_pop   = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Shadow copy of the registers, updated on each csr beat.
   logic [MAX_LINE_BITS-1:0]  cfg_max_line   = MAX_LINE_RESET;
   logic [7:0]                cfg_escape_char = ESCAPE_CHAR_RESET;
   logic                      cfg_escape_ctrl = 1'b1;
   logic                      cfg_drop_lf     = 1'b1;

   // Predictor state for the message in flight.
   logic [7:0]                held_bytes [2];
   int                        held_n        = 0;
   int                        line_len      = 0;
   logic                      first_pending = 1'b1;
   line_mode_e                line_mode     = LINE_OPEN;

   rsp_type                   run_beats [$];      // beats caused by one req beat
   rsp_type                   line_beats_due [$]; // expected rsp beats, oldest first
   logic [7:0]                msg_bytes [$];      // message about to be sent

   int                        bytes_taken  = 0;   // req beats seen by the monitor
   int                        csr_taken    = 0;   // csr beats seen by the monitor
   int                        msg_items    = 0;   // bytes sent that the block acts on
   int                        errors       = 0;
   int                        cycles       = 0;
   int                        tx_idle_pct  = IDLE_PCT;
   int                        rx_idle_pct  = IDLE_PCT;
   int                        hold_ask     = 0;   // pop hold-off requested by a test

   log_line_control_char_escaper_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Line predictor
   // ------------------------------------------------------------------

   function automatic void add_beat(logic [7:0] ob, logic has, logic done, logic dropped);
      rsp_type beat;
      beat.out_byte        = ob;
      beat.has_byte        = has;
      beat.line_done       = done;
      beat.message_dropped = dropped;
      beat.last_of_run     = 1'b0;
      run_beats.push_back(beat);
   endfunction

   // One byte heads for the line: pass it, escape it, drop it or cut the line.
   function automatic void write_line_byte(logic [7:0] b);
      int lim;
      lim = (int'(cfg_max_line) < LINE_COUNT_MAX) ? int'(cfg_max_line) : LINE_COUNT_MAX;
      if (line_mode != LINE_OPEN)
         return;
      if (line_len >= lim) begin
         // limit reached: close the line, swallow the rest of the message
         add_beat(8'h00, 1'b0, 1'b1, 1'b0);
         line_mode = LINE_CUT;
         return;
      end
      if (b == CHAR_NUL || (cfg_escape_ctrl && (b < CTRL_TOP || b == CHAR_DEL))) begin
         // escape needs four slots; without room the byte just vanishes
         if (line_len + 3 < lim) begin
            add_beat(cfg_escape_char, 1'b1, 1'b0, 1'b0);
            add_beat(CHAR_ZERO + {6'b0, b[7:6]}, 1'b1, 1'b0, 1'b0);
            add_beat(CHAR_ZERO + {5'b0, b[5:3]}, 1'b1, 1'b0, 1'b0);
            add_beat(CHAR_ZERO + {5'b0, b[2:0]}, 1'b1, 1'b0, 1'b0);
            line_len += 4;
         end
      end else begin
         add_beat(b, 1'b1, 1'b0, 1'b0);
         line_len += 1;
      end
   endfunction

   // Expected rsp beats for one accepted req beat, appended to line_beats_due.
   function automatic void predict_line_beats(req_type r);
      logic [7:0] tail [3];
      int         k;
      rsp_type    beat;
      run_beats.delete();
      if (first_pending) begin
         first_pending = 1'b0;
         if (r.in_byte == CHAR_Z) begin
            line_mode = LINE_REJECTED;
            add_beat(8'h00, 1'b0, 1'b0, 1'b1);
         end
      end
      if (!r.last_byte) begin
         // two newest bytes stay held back until the message end is known
         if (line_mode == LINE_OPEN) begin
            if (held_n >= 2) begin
               write_line_byte(held_bytes[0]);
               held_bytes[0] = held_bytes[1];
               held_bytes[1] = r.in_byte;
            end else begin
               held_bytes[held_n] = r.in_byte;
               held_n++;
            end
         end
      end else begin
         if (line_mode == LINE_OPEN) begin
            k = 0;
            for (int i = 0; i < held_n; i++) begin
               tail[k] = held_bytes[i];
               k++;
            end
            tail[k] = r.in_byte;
            k++;
            // trailing NUL goes first, then a trailing LF if enabled
            if (r.in_byte == CHAR_NUL)
               k--;
            if (cfg_drop_lf && k > 0 && tail[k-1] == CHAR_LF)
               k--;
            for (int i = 0; i < k; i++)
               write_line_byte(tail[i]);
            if (line_mode == LINE_OPEN)
               add_beat(8'h00, 1'b0, 1'b1, 1'b0);
         end
         held_n        = 0;
         line_len      = 0;
         first_pending = 1'b1;
         line_mode     = LINE_OPEN;
      end
      foreach (run_beats[i]) begin
         beat             = run_beats[i];
         beat.last_of_run = (i == run_beats.size() - 1);
         line_beats_due.push_back(beat);
      end
   endfunction

   task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: all beats sampled at the rising edge. req beats are predicted
   // before the rsp beat of the same edge is checked.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAX_LINE:         cfg_max_line    = csr_wdata[MAX_LINE_BITS-1:0];
               REG_ESCAPE_CHAR:      cfg_escape_char = csr_wdata[7:0];
               REG_ESCAPE_CONTROL:   cfg_escape_ctrl = csr_wdata[0];
               REG_DROP_TRAILING_LF: cfg_drop_lf     = csr_wdata[0];
               default: ;
            endcase
            csr_taken++;
         end
         if (req_push && !req_full) begin
            predict_line_beats(req_data);
            bytes_taken++;
         end
         if (rsp_pop && !rsp_empty) begin
            if (line_beats_due.size() == 0) begin
               $error("rsp beat with nothing expected: %h", rsp_data);
               errors++;
            end else begin
               want = line_beats_due.pop_front();
               check_field("out_byte", want.out_byte, rsp_data.out_byte);
               check_field("has_byte", want.has_byte, rsp_data.has_byte);
               check_field("line_done", want.line_done, rsp_data.line_done);
               check_field("message_dropped", want.message_dropped,
                           rsp_data.message_dropped);
               check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
            end
         end
      end
   end

   // Hard stop if the block wedges.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Receiver: random pop with an optional long hold-off, counted here.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_ask != 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender side. Tasks start and end on a falling edge; push stays high
   // after a beat so back-to-back bytes need no gap.
   // ------------------------------------------------------------------

   task automatic push_byte(logic [7:0] b, logic last);
      int seen;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_data <= {b, last};
      req_push <= 1'b1;
      seen = bytes_taken;
      do @(negedge clock); while (bytes_taken == seen);
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_bytes.size(); i++)
         push_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      // bytes after a rejecting 'z' are ignored by the block
      msg_items += (msg_bytes[0] == CHAR_Z) ? 1 : msg_bytes.size();
   endtask

   // Stop offering and let the block run dry before touching registers.
   task automatic settle();
      req_push <= 1'b0;
      while (line_beats_due.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      int seen;
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      seen = csr_taken;
      do @(negedge clock); while (csr_taken == seen);
   endtask

   // Upper data bits are junk on the narrow registers; the block must mask them.
   task automatic set_config(logic [15:0] max_line, logic [7:0] esc, logic ctrl, logic lf);
      settle();
      write_reg(REG_MAX_LINE, max_line);
      write_reg(REG_ESCAPE_CHAR, {8'($urandom), esc});
      write_reg(REG_ESCAPE_CONTROL, {15'($urandom), ctrl});
      write_reg(REG_DROP_TRAILING_LF, {15'($urandom), lf});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] random_byte();
      case ($urandom_range(9))
         0:       return CHAR_NUL;
         1:       return CHAR_LF;
         2:       return 8'($urandom_range(1, 31));
         3:       return CHAR_DEL;
         4:       return 8'($urandom_range(128, 255));
         5:       return CHAR_Z;
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   // Mostly short messages; some long ones to run into small line limits.
   // Endings favor the trailing NUL / LF trim paths.
   function automatic void make_random_message();
      int len;
      msg_bytes.delete();
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
      if ($urandom_range(9) == 0)
         msg_bytes.push_back(CHAR_Z);
      while (msg_bytes.size() < len)
         msg_bytes.push_back(random_byte());
      case ($urandom_range(9))
         0, 1, 2: msg_bytes[msg_bytes.size()-1] = CHAR_LF;
         3, 4:    msg_bytes[msg_bytes.size()-1] = CHAR_NUL;
         5: begin
            msg_bytes.push_back(CHAR_LF);
            msg_bytes.push_back(CHAR_NUL);
         end
         default: ;
      endcase
   endfunction

   task automatic run_phase(int n, logic [15:0] max_line, logic [7:0] esc,
                            logic ctrl, logic lf);
      int start;
      set_config(max_line, esc, ctrl, lf);
      start = msg_items;
      while (msg_items - start < n) begin
         make_random_message();
         send_message();
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset register values: trimming, rejection, byte extremes.
   task automatic test_trim_and_reject();
      msg_bytes = '{CHAR_NUL};                 // NUL trim empties the line
      send_message();
      msg_bytes = '{CHAR_LF};                  // LF trim empties the line
      send_message();
      msg_bytes = '{CHAR_Z, 8'h61, 8'h62};     // rejected, rest ignored
      send_message();
      msg_bytes = '{CHAR_Z};                   // rejected on its last byte
      send_message();
      // high bytes, DEL, control range edges, trailing LF then NUL
      msg_bytes = '{8'hFF, 8'h80, CHAR_DEL, 8'h01, 8'h1F, CTRL_TOP, 8'h7E,
                    CHAR_LF, CHAR_NUL};
      send_message();
   endtask

   // Limit of zero cuts at once; limit of five drops an escape with no room
   // and then cuts the line on the last byte.
   task automatic test_line_limit();
      set_config(16'd0, ESCAPE_CHAR_RESET, 1'b1, 1'b1);
      msg_bytes = '{8'h61, 8'h62};
      send_message();
      set_config(16'd5, ESCAPE_CHAR_RESET, 1'b1, 1'b1);
      msg_bytes = '{8'h61, 8'h62, 8'h01, 8'h63, 8'h64, 8'h65, 8'h66};
      send_message();
   endtask

   // Receiver holds off while the sender keeps pushing: req_full must rise
   // and the block must lose nothing.
   task automatic test_backpressure();
      set_config(MAX_LINE_RESET, ESCAPE_CHAR_RESET, 1'b1, 1'($urandom));
      msg_bytes.delete();
      msg_bytes.push_back(8'h41);
      while (msg_bytes.size() < 40)
         msg_bytes.push_back(($urandom_range(1) == 0) ? 8'($urandom_range(0, 31))
                                                      : random_byte());
      tx_idle_pct = 0;
      hold_ask    = 200;
      send_message();
      tx_idle_pct = IDLE_PCT;
   endtask

   // Random messages under several register settings, extremes included.
   task automatic test_random_phases();
      run_phase(35, MAX_LINE_RESET, ESCAPE_CHAR_RESET, 1'b1, 1'b1);
      run_phase(35, 16'd8, 8'h00, 1'b0, 1'b0);
      run_phase(35, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
      // stretch with no idling on either side
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_phase(35, 16'($urandom_range(0, 24)), 8'($urandom), 1'($urandom), 1'($urandom));
      tx_idle_pct = IDLE_PCT;
      rx_idle_pct = IDLE_PCT;
      run_phase(35, ($urandom_range(9) < 3) ? 16'($urandom_range(0, 7))
                                            : 16'($urandom_range(8, 40)),
                8'($urandom), 1'($urandom), 1'($urandom));
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_trim_and_reject();
      test_line_limit();
      test_backpressure();
      test_random_phases();
      // drain, then leave room for any stray beat to show up
      settle();
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
